// ----- hw/rtl/bcd_clock_up_down_counter_defines.svh -----
// Assertion macros for the BCD clock counter.
// Define ASSERT_OFF to compile them out; no other dependencies.
`ifndef BCD_CLOCK_UP_DOWN_COUNTER_DEFINES_SVH
`define BCD_CLOCK_UP_DOWN_COUNTER_DEFINES_SVH

`ifndef ASSERT_OFF

`define BCDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BCDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define BCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/bcdc_pkg.sv -----
// Types and constants of the BCD clock counter: event codes, adjust targets,
// digit limits and the packed clock state. No dependencies.
package bcdc_pkg;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_CLEAR    = 3'd1,
        OP_PAUSE    = 3'd2,
        OP_RESUME   = 3'd3,
        OP_TOGGLE   = 3'd4,
        OP_EXIT_ADJ = 3'd5,
        OP_ADJ_UP   = 3'd6,
        OP_ADJ_DOWN = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        UNIT_SEC  = 2'd0,
        UNIT_MIN  = 2'd1,
        UNIT_HOUR = 2'd2
    } unit_t;

    localparam logic [3:0] ONES_MAX       = 4'd9;
    localparam logic [2:0] TENS_MAX       = 3'd5;
    localparam logic [1:0] HOUR_TENS_MAX  = 2'd2;
    localparam logic [3:0] HOUR_ONES_LAST = 4'd3;

    // Packed so that the seconds units digit sits in the lowest bits.
    typedef struct packed {
        logic       alarm;
        logic       adjusting;
        logic       running;
        logic       down_dir;
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
    } clk_state_t;

    localparam clk_state_t CLOCK_RESET = '{
        alarm:     1'b0,
        adjusting: 1'b0,
        running:   1'b1,
        down_dir:  1'b0,
        hour_tens: 2'd0,
        hour_ones: 4'd0,
        min_tens:  3'd0,
        min_ones:  4'd0,
        sec_tens:  3'd0,
        sec_ones:  4'd0
    };

endpackage

// ----- hw/rtl/bcd_clock_up_down_counter.sv -----
// BCD HH:MM:SS clock counter with up/down counting and digit adjust.
// Depends on bcdc_pkg and bcd_clock_up_down_counter_defines.svh.
//
// Each input item is one event (op in tdata[2:0], adjust target in tdata[4:3])
// and yields exactly one result item: the six time digits and the four mode
// flags after that event. The event is applied to the state register in the
// cycle it is accepted and the result lands in a single output register, so
// one item is taken per clock while results drain, and a result appears in
// the cycle after its item. A new item is accepted whenever the output
// register is empty or is being drained in the same cycle. Reset clears the
// time to 00:00:00, counting up and running, with adjust mode and the alarm off.
`include "bcd_clock_up_down_counter_defines.svh"

module bcd_clock_up_down_counter
    import bcdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // op[2:0], unit[4:3], zero[7:5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // sec_ones[3:0], sec_tens[6:4], min_ones[10:7],
                                        // min_tens[13:11], hour_ones[17:14],
                                        // hour_tens[19:18], down_dir[20],
                                        // running[21], adjusting[22], alarm[23]
);

    clk_state_t state_reg;
    clk_state_t state_next;
    clk_state_t out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    clk_state_t up_cnt;
    clk_state_t down_cnt;
    clk_state_t adj_st;
    op_t        op;
    unit_t      unit;
    logic       s_fire;
    logic       m_fire;

    assign op            = op_t'(s_axis_tdata[2:0]);
    assign unit          = unit_t'(s_axis_tdata[4:3]);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // Count up: ripple through the digits, wrap past 23:59:59.
    always_comb
    begin
        up_cnt = state_reg;
        if (state_reg.sec_ones < ONES_MAX)
        begin
            up_cnt.sec_ones = state_reg.sec_ones + 4'd1;
        end
        else
        begin
            up_cnt.sec_ones = '0;
            if (state_reg.sec_tens < TENS_MAX)
            begin
                up_cnt.sec_tens = state_reg.sec_tens + 3'd1;
            end
            else
            begin
                up_cnt.sec_tens = '0;
                if (state_reg.min_ones < ONES_MAX)
                begin
                    up_cnt.min_ones = state_reg.min_ones + 4'd1;
                end
                else
                begin
                    up_cnt.min_ones = '0;
                    if (state_reg.min_tens < TENS_MAX)
                    begin
                        up_cnt.min_tens = state_reg.min_tens + 3'd1;
                    end
                    else
                    begin
                        up_cnt.min_tens = '0;
                        if (state_reg.hour_tens >= HOUR_TENS_MAX &&
                            state_reg.hour_ones >= HOUR_ONES_LAST)
                        begin
                            up_cnt.hour_ones = '0;
                            up_cnt.hour_tens = '0;
                        end
                        else if (state_reg.hour_ones < ONES_MAX)
                        begin
                            up_cnt.hour_ones = state_reg.hour_ones + 4'd1;
                        end
                        else
                        begin
                            up_cnt.hour_ones = '0;
                            up_cnt.hour_tens = (state_reg.hour_tens >= HOUR_TENS_MAX) ?
                                               2'd0 : state_reg.hour_tens + 2'd1;
                        end
                    end
                end
            end
        end
    end

    // Count down: borrow from the lowest nonzero digit, stop at zero and raise alarm.
    always_comb
    begin
        down_cnt = state_reg;
        if (state_reg.sec_ones != '0)
        begin
            down_cnt.sec_ones = state_reg.sec_ones - 4'd1;
        end
        else if (state_reg.sec_tens != '0)
        begin
            down_cnt.sec_tens = state_reg.sec_tens - 3'd1;
            down_cnt.sec_ones = ONES_MAX;
        end
        else if (state_reg.min_ones != '0)
        begin
            down_cnt.min_ones = state_reg.min_ones - 4'd1;
            down_cnt.sec_ones = ONES_MAX;
            down_cnt.sec_tens = TENS_MAX;
        end
        else if (state_reg.min_tens != '0)
        begin
            down_cnt.min_tens = state_reg.min_tens - 3'd1;
            down_cnt.sec_ones = ONES_MAX;
            down_cnt.sec_tens = TENS_MAX;
            down_cnt.min_ones = ONES_MAX;
        end
        else if (state_reg.hour_ones != '0)
        begin
            down_cnt.hour_ones = state_reg.hour_ones - 4'd1;
            down_cnt.sec_ones  = ONES_MAX;
            down_cnt.sec_tens  = TENS_MAX;
            down_cnt.min_ones  = ONES_MAX;
            down_cnt.min_tens  = TENS_MAX;
        end
        else if (state_reg.hour_tens != '0)
        begin
            down_cnt.hour_tens = state_reg.hour_tens - 2'd1;
            down_cnt.sec_ones  = ONES_MAX;
            down_cnt.sec_tens  = TENS_MAX;
            down_cnt.min_ones  = ONES_MAX;
            down_cnt.min_tens  = TENS_MAX;
            down_cnt.hour_ones = ONES_MAX;
        end
        else
        begin
            down_cnt.alarm = 1'b1;
        end
    end

    // Adjust: step up with carry into a wrapping tens digit, step down saturating.
    always_comb
    begin
        adj_st = state_reg;
        case (unit)
            UNIT_SEC:
            begin
                if (op == OP_ADJ_UP)
                begin
                    if (state_reg.sec_ones >= ONES_MAX)
                    begin
                        adj_st.sec_ones = '0;
                        adj_st.sec_tens = (state_reg.sec_tens >= TENS_MAX) ?
                                          3'd0 : state_reg.sec_tens + 3'd1;
                    end
                    else
                    begin
                        adj_st.sec_ones = state_reg.sec_ones + 4'd1;
                    end
                end
                else if (state_reg.sec_ones != '0)
                begin
                    adj_st.sec_ones = state_reg.sec_ones - 4'd1;
                end
            end
            UNIT_MIN:
            begin
                if (op == OP_ADJ_UP)
                begin
                    if (state_reg.min_ones >= ONES_MAX)
                    begin
                        adj_st.min_ones = '0;
                        adj_st.min_tens = (state_reg.min_tens >= TENS_MAX) ?
                                          3'd0 : state_reg.min_tens + 3'd1;
                    end
                    else
                    begin
                        adj_st.min_ones = state_reg.min_ones + 4'd1;
                    end
                end
                else if (state_reg.min_ones != '0)
                begin
                    adj_st.min_ones = state_reg.min_ones - 4'd1;
                end
            end
            UNIT_HOUR:
            begin
                if (op == OP_ADJ_UP)
                begin
                    if (state_reg.hour_ones >= ONES_MAX)
                    begin
                        adj_st.hour_ones = '0;
                        adj_st.hour_tens = (state_reg.hour_tens >= HOUR_TENS_MAX) ?
                                           2'd0 : state_reg.hour_tens + 2'd1;
                    end
                    else
                    begin
                        adj_st.hour_ones = state_reg.hour_ones + 4'd1;
                    end
                end
                else if (state_reg.hour_ones != '0)
                begin
                    adj_st.hour_ones = state_reg.hour_ones - 4'd1;
                end
            end
            default:
            begin
                adj_st = state_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (op)
            OP_TICK:
            begin
                if (state_reg.running)
                begin
                    state_next = state_reg.down_dir ? down_cnt : up_cnt;
                end
            end
            OP_CLEAR:
            begin
                state_next.sec_ones  = '0;
                state_next.sec_tens  = '0;
                state_next.min_ones  = '0;
                state_next.min_tens  = '0;
                state_next.hour_ones = '0;
                state_next.hour_tens = '0;
            end
            OP_PAUSE:
            begin
                state_next.running = 1'b0;
            end
            OP_RESUME:
            begin
                state_next.running = 1'b1;
            end
            OP_TOGGLE:
            begin
                state_next.running   = 1'b0;
                state_next.down_dir  = !state_reg.down_dir;
                state_next.adjusting = 1'b1;
            end
            OP_EXIT_ADJ:
            begin
                state_next.adjusting = 1'b0;
            end
            OP_ADJ_UP, OP_ADJ_DOWN:
            begin
                if (state_reg.adjusting)
                begin
                    state_next = adj_st;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLOCK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_reg <= state_next;
        end
    end

    `BCDC_ASSERT_NEXT(a_alarm_sticky, clk, rst_n, state_reg.alarm, state_reg.alarm)
    `BCDC_ASSERT_IMPLY(a_digits_range, clk, rst_n, 1'b1,
        state_reg.sec_ones <= ONES_MAX && state_reg.sec_tens <= TENS_MAX &&
        state_reg.min_ones <= ONES_MAX && state_reg.min_tens <= TENS_MAX &&
        state_reg.hour_ones <= ONES_MAX && state_reg.hour_tens <= HOUR_TENS_MAX)
    `BCDC_ASSERT_NEXT(a_toggle_enters_adjust, clk, rst_n, s_fire && op == OP_TOGGLE,
        out_reg.adjusting && !out_reg.running && out_valid_reg)
    `BCDC_ASSERT_IMPLY(a_no_accept_when_full, clk, rst_n,
        out_valid_reg && !m_axis_tready, !s_axis_tready)
    `BCDC_ASSERT_NEXT(a_result_is_state, clk, rst_n, s_fire, out_reg == state_reg)

endmodule
